// ===== sv/attw_pkg.sv =====
// Shared types and constants for the attention weight ramp block.
`timescale 1ns / 1ps

package attw_pkg;

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 24;
   localparam int DivSteps      = 32;
   localparam int DivCountWidth = $clog2(DivSteps);

   localparam logic [CsrIndexWidth-1:0] RegMaxStep = 2'd0;
   localparam logic [CsrIndexWidth-1:0] RegHold    = 2'd1;
   localparam logic [CsrIndexWidth-1:0] RegEngage  = 2'd2;
   localparam logic [CsrIndexWidth-1:0] RegRelease = 2'd3;

   localparam logic [15:0] MaxStepReset = 16'd100;
   localparam logic [23:0] HoldReset    = 24'd3000;
   localparam logic [15:0] EngageReset  = 16'd300;
   localparam logic [15:0] ReleaseReset = 16'd600;

   localparam logic [16:0] OneQ16   = 17'h10000;
   localparam logic [17:0] ThreeQ16 = 18'h30000;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        cursor_moved;
      logic        pin_active;
      logic        track_enabled;
      logic        track_suppressed;
   } req_type;

   typedef struct packed {
      logic        write_focus;
      logic [16:0] focus_weight;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage

// ===== sv/attw_div.sv =====
// Restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps

module attw_div (
   input  logic                  clock,
   input  logic                  reset,
   input  attw_pkg::div_req_type div_req,
   output attw_pkg::div_rsp_type div_rsp
);

   logic                               busy_ff;
   logic                               done_ff;
   logic [attw_pkg::DivCountWidth-1:0] count_ff;
   logic [16:0]                        rem_ff;
   logic [31:0]                        quo_ff;
   logic [15:0]                        divisor_ff;

   logic [16:0] rem_shift;
   logic [17:0] diff;
   logic        fits;

   assign rem_shift = {rem_ff[15:0], quo_ff[31]};
   assign diff      = {1'b0, rem_shift} - {2'b00, divisor_ff};
   assign fits      = ~diff[17];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && count_ff == attw_pkg::DivCountWidth'(attw_pkg::DivSteps - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         count_ff   <= '0;
         rem_ff     <= '0;
         quo_ff     <= div_req.dividend;
         divisor_ff <= div_req.divisor;
      end else if (busy_ff) begin
         count_ff <= count_ff + 1'b1;
         rem_ff   <= fits ? diff[16:0] : rem_shift;
         quo_ff   <= {quo_ff[30:0], fits};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== sv/attention_weight_ramp_unit.sv =====
// Top level of the attention weight ramp: tick sequencer, weight state and smoothstep.
//
// Usage: one item goes in on req_ (timestamp and flags) and exactly one item comes
// out on rsp_ for it (write flag and smoothstepped weight, Q1.16). Items are taken
// one at a time; req_ready is high only while the sequencer waits for a new item.
// When pinned, an item goes from the prep state straight to the output; when the
// ramp span is zero, the weight is set to its target; otherwise the divider for the
// ramp step yields one quotient bit per cycle. Then three passes of one shared 17x18
// multiplier give the smoothstep, unless pinned or the weight is zero with no target.
// A new item is taken only once the previous result is in the output register.
// The result sits in an output register, so a stalled receiver only holds the
// sequencer once a second result is ready to go out; the waiting item holds.
// The user must write configuration through csr_ only while idle (the block does not
// enforce it), one write per cycle, with no read-back. Reset (synchronous, active high)
// restores register defaults, clears the weight, tick and move records, empties output.
`timescale 1ns / 1ps

module attention_weight_ramp_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  attw_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output attw_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write_en,
   input  logic [attw_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [attw_pkg::CsrDataWidth-1:0]     csr_wdata
);

   localparam logic [3:0] StIdle  = 4'd0;
   localparam logic [3:0] StPrep  = 4'd1;
   localparam logic [3:0] StDiv   = 4'd2;
   localparam logic [3:0] StCheck = 4'd3;
   localparam logic [3:0] StSq    = 4'd4;
   localparam logic [3:0] StLo    = 4'd5;
   localparam logic [3:0] StHi    = 4'd6;
   localparam logic [3:0] StSum   = 4'd7;
   localparam logic [3:0] StOut   = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   logic [15:0] max_step_ff;
   logic [23:0] hold_ff;
   logic [15:0] engage_ff;
   logic [15:0] release_ff;

   logic [16:0] weight_ff;
   logic [31:0] prev_time_ff;
   logic        tick_seen_ff;
   logic [31:0] move_time_ff;
   logic        move_seen_ff;
   logic        settled_ff;

   attw_pkg::req_type item_ff;
   logic              target_ff;
   logic              rising_ff;
   logic [17:0]       k_ff;
   logic [16:0]       sq_hi_ff;
   logic [34:0]       lo_ff;
   logic [34:0]       prod_ff;
   attw_pkg::rsp_type res_ff;
   attw_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;

   attw_pkg::div_req_type div_req;
   attw_pkg::div_rsp_type div_rsp;

   logic [31:0] now;
   logic [31:0] elapsed;
   logic [15:0] dt_calc;
   logic [31:0] move_time_eff;
   logic        move_seen_eff;
   logic [31:0] since_move;
   logic        recent;
   logic        target_calc;
   logic        rising_calc;
   logic [15:0] span;
   logic [16:0] target_w;
   logic [16:0] target_calc_w;
   logic [32:0] up_sum;
   logic [32:0] floor_w;
   logic [16:0] ramped;
   logic [16:0] mul_a;
   logic [17:0] mul_b;
   logic [34:0] mul_out;
   logic [51:0] total;
   logic        load_out;

   attw_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign now           = item_ff.now_ms;
   assign elapsed       = now - prev_time_ff;
   assign move_time_eff = item_ff.cursor_moved ? now : move_time_ff;
   assign move_seen_eff = item_ff.cursor_moved | move_seen_ff;
   assign since_move    = now - move_time_eff;
   assign recent        = (now < move_time_eff) || (since_move < {8'd0, hold_ff});
   assign target_calc   = item_ff.track_enabled & ~item_ff.track_suppressed &
                          move_seen_eff & recent;
   assign rising_calc   = target_calc && (weight_ff != attw_pkg::OneQ16);
   assign span          = rising_calc ? engage_ff : release_ff;
   assign target_calc_w = target_calc ? attw_pkg::OneQ16 : 17'd0;
   assign target_w      = target_ff ? attw_pkg::OneQ16 : 17'd0;

   always_comb begin
      dt_calc = '0;
      if (tick_seen_ff && now >= prev_time_ff) begin
         dt_calc = (elapsed > {16'd0, max_step_ff}) ? max_step_ff : elapsed[15:0];
      end
   end

   assign div_req.start    = (state_ff == StPrep) && !item_ff.pin_active && (span != 16'd0);
   assign div_req.dividend = {dt_calc, 16'd0};
   assign div_req.divisor  = span;

   assign up_sum  = {16'd0, weight_ff} + {1'b0, div_rsp.quotient};
   assign floor_w = {16'd0, target_w} + {1'b0, div_rsp.quotient};

   always_comb begin
      if (rising_ff) begin
         ramped = (up_sum > {16'd0, target_w}) ? target_w : up_sum[16:0];
      end else begin
         ramped = ({16'd0, weight_ff} <= floor_w) ? target_w
                                                  : weight_ff - div_rsp.quotient[16:0];
      end
   end

   always_comb begin
      case (state_ff)
         StLo: begin
            mul_a = prod_ff[16:0];
            mul_b = k_ff;
         end
         StHi: begin
            mul_a = sq_hi_ff;
            mul_b = k_ff;
         end
         default: begin
            mul_a = weight_ff;
            mul_b = {1'b0, weight_ff};
         end
      endcase
   end

   assign mul_out  = {18'd0, mul_a} * {17'd0, mul_b};
   assign total    = {prod_ff, 17'd0} + {17'd0, lo_ff};
   assign load_out = (state_ff == StOut) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               state_in = StPrep;
            end
         end
         StPrep: begin
            if (item_ff.pin_active) begin
               state_in = StOut;
            end else if (span == 16'd0) begin
               state_in = StCheck;
            end else begin
               state_in = StDiv;
            end
         end
         StDiv: begin
            if (div_rsp.done) begin
               state_in = StCheck;
            end
         end
         StCheck: begin
            if (weight_ff == 17'd0 && !target_ff) begin
               state_in = StOut;
            end else begin
               state_in = StSq;
            end
         end
         StSq:  state_in = StLo;
         StLo:  state_in = StHi;
         StHi:  state_in = StSum;
         StSum: state_in = StOut;
         StOut: begin
            if (load_out) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_step_ff <= attw_pkg::MaxStepReset;
         hold_ff     <= attw_pkg::HoldReset;
         engage_ff   <= attw_pkg::EngageReset;
         release_ff  <= attw_pkg::ReleaseReset;
      end else if (csr_write_en) begin
         case (csr_index)
            attw_pkg::RegMaxStep: max_step_ff <= csr_wdata[15:0];
            attw_pkg::RegHold:    hold_ff     <= csr_wdata;
            attw_pkg::RegEngage:  engage_ff   <= csr_wdata[15:0];
            attw_pkg::RegRelease: release_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff    <= '0;
         prev_time_ff <= '0;
         tick_seen_ff <= 1'b0;
         move_time_ff <= '0;
         move_seen_ff <= 1'b0;
         settled_ff   <= 1'b0;
      end else begin
         case (state_ff)
            StPrep: begin
               prev_time_ff <= now;
               tick_seen_ff <= 1'b1;
               if (item_ff.pin_active) begin
                  weight_ff    <= '0;
                  move_time_ff <= '0;
                  move_seen_ff <= 1'b0;
                  settled_ff   <= 1'b0;
               end else begin
                  move_time_ff <= move_time_eff;
                  move_seen_ff <= move_seen_eff;
                  if (span == 16'd0) begin
                     weight_ff <= target_calc_w;
                  end
               end
            end
            StDiv: begin
               if (div_rsp.done) begin
                  weight_ff <= ramped;
               end
            end
            StCheck: begin
               settled_ff <= (weight_ff == 17'd0) && !target_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         StIdle: begin
            item_ff <= req_data;
         end
         StPrep: begin
            target_ff <= target_calc;
            rising_ff <= rising_calc;
            res_ff    <= '0;
         end
         StCheck: begin
            res_ff.write_focus  <= !settled_ff;
            res_ff.focus_weight <= '0;
         end
         StSq: begin
            prod_ff <= mul_out;
            k_ff    <= attw_pkg::ThreeQ16 - {weight_ff, 1'b0};
         end
         StLo: begin
            sq_hi_ff <= prod_ff[33:17];
            prod_ff  <= mul_out;
         end
         StHi: begin
            lo_ff   <= prod_ff;
            prod_ff <= mul_out;
         end
         StSum: begin
            res_ff.write_focus  <= 1'b1;
            res_ff.focus_weight <= total[48:32];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ff <= res_ff;
      end
   end

   assign req_ready = (state_ff == StIdle);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
